[hw/rtl/mep_pkg.sv]
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types and constants of the Mandelbrot escape-time pixel engine.
// ----------------------------------------------------------------------------
package mep_pkg;

    localparam int INDEX_BITS_DEF    = 7;
    localparam int FRACTION_BITS_DEF = 12;

    // Field widths of the words on the ports.
    localparam int FIELD_INDEX_BITS = 7;
    localparam int ORIGIN_BITS      = 16;
    localparam int STEP_BITS        = 15;
    localparam int COUNT_BITS       = 4;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int CFG_DATA_BITS    = 16;

    // The count field is four bits wide, so at most fifteen iteration units.
    localparam int MAX_ITER = 15;

    localparam int COLOR_HIGH_SHIFT = 19;
    localparam int COLOR_LOW_SHIFT  = 2;
    localparam int COLOR_HIGH_BITS  = 23;
    localparam int COLOR_LOW_BITS   = 6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REAL_ORIGIN     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAG_ORIGIN     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REAL_STEP       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAG_STEP       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ITERATION_LIMIT = 3'd4;

    // Reset values: origins at -2.0, steps of 4.0/128, full iteration limit.
    localparam logic signed [ORIGIN_BITS-1:0] REAL_ORIGIN_RESET = -16'sd8192;
    localparam logic signed [ORIGIN_BITS-1:0] IMAG_ORIGIN_RESET = -16'sd8192;
    localparam logic [STEP_BITS-1:0]          REAL_STEP_RESET   = 15'd128;
    localparam logic [STEP_BITS-1:0]          IMAG_STEP_RESET   = 15'd128;
    localparam logic [COUNT_BITS-1:0]         LIMIT_RESET       = 4'd15;

    typedef struct packed {
        logic [FIELD_INDEX_BITS-1:0] column;
        logic [FIELD_INDEX_BITS-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]      remaining_count;
        logic [COLOR_HIGH_BITS-1:0] color_word_high;
        logic [COLOR_LOW_BITS-1:0]  color_word_low;
    } result_t;

    // Control that travels with each pixel down the iteration pipeline.
    typedef struct packed {
        logic                  valid;
        logic                  done;
        logic [COUNT_BITS-1:0] count;
    } ctl_t;

endpackage

[hw/rtl/mep_iter.sv]
// ----------------------------------------------------------------------------
// mep_iter
// One iteration z = z^2 + c as two pipeline stages: products, then update.
// ----------------------------------------------------------------------------
module mep_iter
    import mep_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ctl_t                              ctl_in,
    input  logic signed [FRACTION_BITS+3:0]   zr_in,
    input  logic signed [FRACTION_BITS+3:0]   zi_in,
    input  logic signed [FRACTION_BITS+3:0]   cr_in,
    input  logic signed [FRACTION_BITS+3:0]   ci_in,
    output ctl_t                              ctl_out,
    output logic signed [FRACTION_BITS+3:0]   zr_out,
    output logic signed [FRACTION_BITS+3:0]   zi_out,
    output logic signed [FRACTION_BITS+3:0]   cr_out,
    output logic signed [FRACTION_BITS+3:0]   ci_out
);

    localparam int W  = FRACTION_BITS + 4;
    localparam int PW = 2 * W;

    localparam logic signed [W-1:0] FIX_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] FIX_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0] ESCAPE_BOUND = (W+1)'(4) << FRACTION_BITS;

    // Stage A: products.
    ctl_t                   ctl_a_reg;
    logic signed [PW-1:0]   p_rr_reg;
    logic signed [PW-1:0]   p_ii_reg;
    logic signed [PW-1:0]   p_ri_reg;
    logic signed [W-1:0]    cr_a_reg;
    logic signed [W-1:0]    ci_a_reg;

    // Stage B: updated z.
    ctl_t                   ctl_b_reg;
    ctl_t                   ctl_b_next;
    logic signed [W-1:0]    zr_reg;
    logic signed [W-1:0]    zr_next;
    logic signed [W-1:0]    zi_reg;
    logic signed [W-1:0]    zi_next;
    logic signed [W-1:0]    cr_b_reg;
    logic signed [W-1:0]    ci_b_reg;

    logic signed [PW-1:0]   rr_shift;
    logic signed [PW-1:0]   ii_shift;
    logic signed [PW:0]     ri_shift;
    logic signed [W-1:0]    rr_sat;
    logic signed [W-1:0]    ii_sat;
    logic signed [W-1:0]    ri_sat;
    logic signed [W+1:0]    sum_r;
    logic signed [W:0]      sum_i;
    logic [W:0]             mag_sum;
    logic                   escape;
    logic                   active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg <= PW'(zr_in) * PW'(zr_in);
        p_ii_reg <= PW'(zi_in) * PW'(zi_in);
        p_ri_reg <= PW'(zr_in) * PW'(zi_in);
        cr_a_reg <= cr_in;
        ci_a_reg <= ci_in;
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        cr_b_reg <= cr_a_reg;
        ci_b_reg <= ci_a_reg;
    end

    always_comb
    begin
        rr_shift = p_rr_reg >>> FRACTION_BITS;
        ii_shift = p_ii_reg >>> FRACTION_BITS;
        // The cross product is doubled before the shift.
        ri_shift = $signed({p_ri_reg, 1'b0}) >>> FRACTION_BITS;

        if (rr_shift > PW'(FIX_MAX))
            rr_sat = FIX_MAX;
        else
            rr_sat = rr_shift[W-1:0];

        if (ii_shift > PW'(FIX_MAX))
            ii_sat = FIX_MAX;
        else
            ii_sat = ii_shift[W-1:0];

        if (ri_shift > (PW+1)'(FIX_MAX))
            ri_sat = FIX_MAX;
        else if (ri_shift < (PW+1)'(FIX_MIN))
            ri_sat = FIX_MIN;
        else
            ri_sat = ri_shift[W-1:0];

        sum_r = (W+2)'(rr_sat) - (W+2)'(ii_sat) + (W+2)'(cr_a_reg);
        sum_i = (W+1)'(ri_sat) + (W+1)'(ci_a_reg);

        if (sum_r > (W+2)'(FIX_MAX))
            zr_next = FIX_MAX;
        else if (sum_r < (W+2)'(FIX_MIN))
            zr_next = FIX_MIN;
        else
            zr_next = sum_r[W-1:0];

        if (sum_i > (W+1)'(FIX_MAX))
            zi_next = FIX_MAX;
        else if (sum_i < (W+1)'(FIX_MIN))
            zi_next = FIX_MIN;
        else
            zi_next = sum_i[W-1:0];

        // Both squares are never negative, so their sum is taken unsigned.
        mag_sum = {1'b0, rr_sat} + {1'b0, ii_sat};
        escape  = mag_sum > ESCAPE_BOUND;

        active     = ctl_a_reg.valid && !ctl_a_reg.done && (ctl_a_reg.count != '0);
        ctl_b_next = ctl_a_reg;
        if (active)
        begin
            if (escape)
                ctl_b_next.done = 1'b1;
            else
                ctl_b_next.count = ctl_a_reg.count - 1'b1;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign zr_out  = zr_reg;
    assign zi_out  = zi_reg;
    assign cr_out  = cr_b_reg;
    assign ci_out  = ci_b_reg;

endmodule

[hw/rtl/mandelbrot_escape_pixel_top.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top
// Escape-time engine: one pixel word in, one count and color word out.
// ----------------------------------------------------------------------------
// A pixel word (column, row) is taken at a rising edge with start high and
// busy low. Busy stays low: the pipeline takes a new word in every cycle.
// Two stages form the point c from the origin and step registers, then
// fifteen iteration units of two stages each (products, then update and
// escape test) follow. A pixel whose count runs out or that escapes early
// simply rides along to the end, so every word takes the same time.
// The result word is registered after the last iteration unit; it is shown
// on result for exactly one cycle with result_strobe high, and is accepted at
// the edge that ends that cycle; results come out in input order, one per
// pixel, at up to one per cycle. The receiver cannot stall the block.
// Configuration words are taken on the cfg channel whenever cfg_valid is
// high (cfg_ready is always high); they are meant to be written while no
// pixel is in flight. Reset clears the pipeline valid bits and loads the
// default view: origins at -2.0, steps of 4.0/128, iteration limit 15.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top
    import mep_pkg::*;
#(
    parameter int INDEX_BITS    = INDEX_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  pixel_t                    pixel,
    output logic                      result_strobe,
    output result_t                   result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int W  = FRACTION_BITS + 4;
    localparam int MW = FIELD_INDEX_BITS + STEP_BITS;
    localparam int CW = MW + 2;
    localparam int SW = ((CW > W) ? CW : W) + 1;

    localparam logic [FIELD_INDEX_BITS-1:0] INDEX_MASK =
        FIELD_INDEX_BITS'((64'd1 << INDEX_BITS) - 64'd1);
    localparam logic signed [W-1:0] FIX_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] FIX_MIN = {1'b1, {(W-1){1'b0}}};

    logic signed [ORIGIN_BITS-1:0] real_origin_reg;
    logic signed [ORIGIN_BITS-1:0] imag_origin_reg;
    logic [STEP_BITS-1:0]          real_step_reg;
    logic [STEP_BITS-1:0]          imag_step_reg;
    logic [COUNT_BITS-1:0]         limit_reg;

    // Point formation stages.
    logic                  c1_valid_reg;
    logic [COUNT_BITS-1:0] c1_count_reg;
    logic [MW-1:0]         prod_r_reg;
    logic [MW-1:0]         prod_i_reg;
    ctl_t                  c2_ctl_reg;
    logic signed [W-1:0]   cr_reg;
    logic signed [W-1:0]   cr_next;
    logic signed [W-1:0]   ci_reg;
    logic signed [W-1:0]   ci_next;
    logic signed [SW-1:0]  sum_r;
    logic signed [SW-1:0]  sum_i;

    logic                  accept;
    logic [FIELD_INDEX_BITS-1:0] column_masked;
    logic [FIELD_INDEX_BITS-1:0] row_masked;

    ctl_t                  ctl_chain [0:MAX_ITER];
    logic signed [W-1:0]   zr_chain  [0:MAX_ITER];
    logic signed [W-1:0]   zi_chain  [0:MAX_ITER];
    logic signed [W-1:0]   cr_chain  [0:MAX_ITER];
    logic signed [W-1:0]   ci_chain  [0:MAX_ITER];

    logic                  strobe_reg;
    result_t               result_reg;
    logic [COUNT_BITS-1:0] final_count;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_origin_reg <= REAL_ORIGIN_RESET;
            imag_origin_reg <= IMAG_ORIGIN_RESET;
            real_step_reg   <= REAL_STEP_RESET;
            imag_step_reg   <= IMAG_STEP_RESET;
            limit_reg       <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REAL_ORIGIN:     real_origin_reg <= cfg_data;
                CFG_IMAG_ORIGIN:     imag_origin_reg <= cfg_data;
                CFG_REAL_STEP:       real_step_reg   <= cfg_data[STEP_BITS-1:0];
                CFG_IMAG_STEP:       imag_step_reg   <= cfg_data[STEP_BITS-1:0];
                CFG_ITERATION_LIMIT: limit_reg       <= cfg_data[COUNT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    assign column_masked = pixel.column & INDEX_MASK;
    assign row_masked    = pixel.row & INDEX_MASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_ctl_reg   <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            c1_valid_reg     <= accept;
            c2_ctl_reg.valid <= c1_valid_reg;
            c2_ctl_reg.done  <= 1'b0;
            c2_ctl_reg.count <= c1_count_reg;
            strobe_reg       <= ctl_chain[MAX_ITER].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_r_reg   <= MW'(column_masked) * MW'(real_step_reg);
        prod_i_reg   <= MW'(row_masked) * MW'(imag_step_reg);
        c1_count_reg <= limit_reg;
        cr_reg       <= cr_next;
        ci_reg       <= ci_next;
        result_reg   <= '{remaining_count: final_count,
                          color_word_high: COLOR_HIGH_BITS'(final_count) << COLOR_HIGH_SHIFT,
                          color_word_low:  COLOR_LOW_BITS'(final_count) << COLOR_LOW_SHIFT};
    end

    always_comb
    begin
        sum_r = SW'(real_origin_reg) + $signed(SW'(prod_r_reg));
        sum_i = SW'(imag_origin_reg) + $signed(SW'(prod_i_reg));

        if (sum_r > SW'(FIX_MAX))
            cr_next = FIX_MAX;
        else if (sum_r < SW'(FIX_MIN))
            cr_next = FIX_MIN;
        else
            cr_next = sum_r[W-1:0];

        if (sum_i > SW'(FIX_MAX))
            ci_next = FIX_MAX;
        else if (sum_i < SW'(FIX_MIN))
            ci_next = FIX_MIN;
        else
            ci_next = sum_i[W-1:0];
    end

    // The iteration starts with z equal to c.
    assign ctl_chain[0] = c2_ctl_reg;
    assign zr_chain[0]  = cr_reg;
    assign zi_chain[0]  = ci_reg;
    assign cr_chain[0]  = cr_reg;
    assign ci_chain[0]  = ci_reg;

    for (genvar k = 0; k < MAX_ITER; k++)
    begin : g_iter
        mep_iter #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_iter (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_chain[k]),
            .zr_in   (zr_chain[k]),
            .zi_in   (zi_chain[k]),
            .cr_in   (cr_chain[k]),
            .ci_in   (ci_chain[k]),
            .ctl_out (ctl_chain[k+1]),
            .zr_out  (zr_chain[k+1]),
            .zi_out  (zi_chain[k+1]),
            .cr_out  (cr_chain[k+1]),
            .ci_out  (ci_chain[k+1])
        );
    end

    assign final_count   = ctl_chain[MAX_ITER].count;
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule
